// ===== src/two_axis_dda_step_generator_assert.svh =====
// Assertion macros for the two-axis DDA step generator.
// Used by the port checker; no other dependencies.
`ifndef TWO_AXIS_DDA_STEP_GENERATOR_ASSERT_SVH
`define TWO_AXIS_DDA_STEP_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define DDASG_ASSERT_NOW(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("ddasg: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define DDASG_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("ddasg: next-cycle check failed");

`endif

// ===== src/ddasg_pkg.sv =====
// Shared types and constants for the two-axis DDA step generator.
// No dependencies.
package ddasg_pkg;

    localparam int POS_WIDTH_DEF = 24;

    // Item operation codes; code 3 is ignored
    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_MOVE = 2'd1,
        OP_ZERO = 2'd2
    } op_t;

    // Fixed part of a packed result: step_x, step_y, dir_x, dir_y_first,
    // dir_y_second, busy_res, rejected
    localparam int RES_FLAG_W = 7;

endpackage

// ===== src/ddasg_outq.sv =====
// Two-entry result queue between the datapath and the output channel.
// Depends on nothing but its parameter.
module ddasg_outq #(
    parameter int WIDTH = 55
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             space,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             pop;

    assign space     = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== src/ddasg_core.sv =====
// Item register, axis state and single-pass DDA update.
// Depends on ddasg_pkg.
module ddasg_core
    import ddasg_pkg::*;
#(
    parameter int POS_WIDTH = POS_WIDTH_DEF,
    parameter int RES_W     = RES_FLAG_W + 2 * POS_WIDTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           op,
    input  logic [POS_WIDTH-1:0] target_x,
    input  logic [POS_WIDTH-1:0] target_y,
    input  logic                 space,
    output logic                 push,
    output logic [RES_W-1:0]     push_data
);

    localparam int DW = POS_WIDTH + 1;

    // item register
    logic                 stg_valid_reg, stg_valid_next;
    logic [1:0]           stg_op_reg;
    logic [POS_WIDTH-1:0] stg_tx_reg, stg_ty_reg;

    // axis state
    logic [POS_WIDTH-1:0] pos_x_reg, pos_x_next, pos_y_reg, pos_y_next;
    logic [DW-1:0]        dist_x_reg, dist_x_next, dist_y_reg, dist_y_next;
    logic [DW-1:0]        len_reg, len_next;
    logic [DW-1:0]        acc_x_reg, acc_x_next, acc_y_reg, acc_y_next;
    logic [DW-1:0]        ticks_reg, ticks_next;
    logic                 dir_x_reg, dir_x_next, dir_y_reg, dir_y_next;

    logic          busy, accept;
    logic          sx, sy, rej;
    logic [DW-1:0] dx, dy, mag_x, mag_y, sum_x, sum_y;

    assign accept   = in_valid && in_ready;
    assign push     = stg_valid_reg && space;
    assign in_ready = !stg_valid_reg || space;
    assign stg_valid_next = accept || (stg_valid_reg && !space);
    assign busy     = (ticks_reg != '0);

    // deltas widened by one bit so they cannot overflow
    assign dx    = {stg_tx_reg[POS_WIDTH-1], stg_tx_reg} - {pos_x_reg[POS_WIDTH-1], pos_x_reg};
    assign dy    = {stg_ty_reg[POS_WIDTH-1], stg_ty_reg} - {pos_y_reg[POS_WIDTH-1], pos_y_reg};
    assign mag_x = dx[DW-1] ? (~dx + 1'b1) : dx;
    assign mag_y = dy[DW-1] ? (~dy + 1'b1) : dy;
    // accumulator stays below the length, so the sum fits in DW bits
    assign sum_x = acc_x_reg + dist_x_reg;
    assign sum_y = acc_y_reg + dist_y_reg;

    always_comb
    begin
        pos_x_next  = pos_x_reg;
        pos_y_next  = pos_y_reg;
        dist_x_next = dist_x_reg;
        dist_y_next = dist_y_reg;
        len_next    = len_reg;
        acc_x_next  = acc_x_reg;
        acc_y_next  = acc_y_reg;
        ticks_next  = ticks_reg;
        dir_x_next  = dir_x_reg;
        dir_y_next  = dir_y_reg;
        sx  = 1'b0;
        sy  = 1'b0;
        rej = 1'b0;
        if (push)
        begin
            unique case (stg_op_reg)
                OP_TICK:
                begin
                    if (busy)
                    begin
                        sx = (sum_x >= len_reg);
                        sy = (sum_y >= len_reg);
                        acc_x_next = sx ? (sum_x - len_reg) : sum_x;
                        acc_y_next = sy ? (sum_y - len_reg) : sum_y;
                        ticks_next = ticks_reg - 1'b1;
                    end
                end
                OP_MOVE:
                begin
                    if (busy)
                    begin
                        rej = 1'b1;
                    end
                    else
                    begin
                        dir_x_next  = !dx[DW-1];
                        dir_y_next  = !dy[DW-1];
                        dist_x_next = mag_x;
                        dist_y_next = mag_y;
                        len_next    = (mag_x > mag_y) ? mag_x : mag_y;
                        ticks_next  = (mag_x > mag_y) ? mag_x : mag_y;
                        acc_x_next  = '0;
                        acc_y_next  = '0;
                        pos_x_next  = stg_tx_reg;
                        pos_y_next  = stg_ty_reg;
                    end
                end
                OP_ZERO:
                begin
                    if (busy)
                    begin
                        rej = 1'b1;
                    end
                    else
                    begin
                        pos_x_next = '0;
                        pos_y_next = '0;
                    end
                end
                default:
                begin
                    // unused code: item passes with the current state
                end
            endcase
        end
    end

    assign push_data = {sx, sy, dir_x_next, dir_y_next, !dir_y_next,
                        (ticks_next != '0), rej, pos_x_next, pos_y_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            dist_x_reg    <= '0;
            dist_y_reg    <= '0;
            len_reg       <= '0;
            acc_x_reg     <= '0;
            acc_y_reg     <= '0;
            ticks_reg     <= '0;
            dir_x_reg     <= 1'b1;
            dir_y_reg     <= 1'b1;
        end
        else
        begin
            stg_valid_reg <= stg_valid_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            dist_x_reg    <= dist_x_next;
            dist_y_reg    <= dist_y_next;
            len_reg       <= len_next;
            acc_x_reg     <= acc_x_next;
            acc_y_reg     <= acc_y_next;
            ticks_reg     <= ticks_next;
            dir_x_reg     <= dir_x_next;
            dir_y_reg     <= dir_y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stg_op_reg <= op;
            stg_tx_reg <= target_x;
            stg_ty_reg <= target_y;
        end
    end

endmodule

// ===== src/two_axis_dda_step_generator.sv =====
// Each result is held first in the item register and then in the result
// queue before it is offered, and it is taken when out_ready is high.
// Throughput: one item per cycle while the result queue has space; the item
// register and queue let input continue while a result waits to be taken.
// Reset (rst_n, asynchronous): positions, distances, accumulators and
// tick count clear to zero, both directions set, queue empties.
// Top level; depends on ddasg_pkg, ddasg_core and ddasg_outq.
module two_axis_dda_step_generator
    import ddasg_pkg::*;
#(
    parameter int POS_WIDTH = POS_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           op,
    input  logic [POS_WIDTH-1:0] target_x,
    input  logic [POS_WIDTH-1:0] target_y,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 step_x,
    output logic                 step_y,
    output logic                 dir_x,
    output logic                 dir_y_first,
    output logic                 dir_y_second,
    output logic                 busy_res,
    output logic                 rejected,
    output logic [POS_WIDTH-1:0] pos_x,
    output logic [POS_WIDTH-1:0] pos_y
);

    localparam int RES_W = RES_FLAG_W + 2 * POS_WIDTH;

    logic             push, space;
    logic [RES_W-1:0] push_data, out_data;

    ddasg_core #(
        .POS_WIDTH (POS_WIDTH),
        .RES_W     (RES_W)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .target_x  (target_x),
        .target_y  (target_y),
        .space     (space),
        .push      (push),
        .push_data (push_data)
    );

    ddasg_outq #(
        .WIDTH (RES_W)
    ) u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign {step_x, step_y, dir_x, dir_y_first, dir_y_second,
            busy_res, rejected, pos_x, pos_y} = out_data;

endmodule

// ===== src/ddasg_checker.sv =====
// Port-level checker for the two-axis DDA step generator, bound to the top.
// Depends on ddasg_pkg and two_axis_dda_step_generator_assert.svh.
`include "two_axis_dda_step_generator_assert.svh"

module ddasg_checker
    import ddasg_pkg::*;
#(
    parameter int POS_WIDTH = POS_WIDTH_DEF
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic                 step_x,
    input logic                 step_y,
    input logic                 dir_y_first,
    input logic                 dir_y_second,
    input logic                 rejected,
    input logic [POS_WIDTH-1:0] pos_x
);

    // second Y motor always runs opposite the first
    `DDASG_ASSERT_NOW(a_dir_y_pair, clk, rst_n, out_valid, dir_y_second != dir_y_first)
    // a refused item never carries a step
    `DDASG_ASSERT_NOW(a_rej_no_step, clk, rst_n, out_valid && rejected, !step_x && !step_y)
    `DDASG_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                       out_valid && $stable(pos_x) && $stable(step_x))
    // a refused item must not leave the queue stuck: with the output drained
    // the input side is open again
    `DDASG_ASSERT_NEXT(a_in_open, clk, rst_n, !in_valid && !out_valid, in_ready)

endmodule

bind two_axis_dda_step_generator ddasg_checker #(.POS_WIDTH(POS_WIDTH)) u_ddasg_checker (.*);
